[rtl/core/assert_macros.svh]
// assertion helpers for the seek unit checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// implication with the consequent in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[rtl/core/nss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package nss_pkg;

  localparam int unsigned REV_UNITS = 26042;
  localparam int unsigned DIST_START = 26043;
  localparam int unsigned TRACK_LIMIT = 100;

  typedef enum logic [1:0] {
    MODE_SLOT   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TRK,
    ST_HDR,
    ST_SCAN,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        found;
    logic [24:0] data_offset;
    logic [7:0]  sector_status;
    logic [15:0] weak_offset;
    logic [14:0] target_angle;
    logic [14:0] distance;
  } result_t;

endpackage
`default_nettype wire

[rtl/core/nss_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle, 16-bit dividend by 5-bit divisor
module nss_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [4:0]  divisor,
  output logic             done,
  output logic [15:0]      quotient,
  output logic [4:0]       remainder
);

  logic [4:0]  count;
  logic        busy;
  logic [15:0] quo;
  logic [5:0]  rem;
  logic [5:0]  trial;
  logic [5:0]  dvs;

  assign trial = {rem[4:0], quo[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'd16;
      end else if (busy) begin
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= {1'b0, divisor};
    end else if (busy) begin
      if (trial >= dvs) begin
        rem <= trial - dvs;
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem[4:0];

endmodule
`default_nettype wire

[rtl/core/nearest_sector_seek_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sector header table with nearest-rotation lookup. Write items (slot or track
// header) are written while the unit stays idle, ready for the next item. A lookup
// runs a 16-step divider to split the sector into track and sector within track,
// reads the track header, scans the track's slots one a cycle through the slot key
// memory, then, when a slot matches, reads the chosen slot's payload. Sector zero
// or zero sectors per track end the lookup while the divider runs; a track out of
// range ends it once the divider is done. A stalled output holds the finished
// lookup until the output register frees. Slot counts reset to zero at once through
// per-track valid bits; no clearing pass. One item is in work at a time; a finished
// result waits in the output register while the next item is already accepted.
module nearest_sector_seek_unit #(
  parameter int TRACKS = 128,
  parameter int SLOTS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [6:0]  track,
  input  wire logic [4:0]  slot,
  input  wire logic [7:0]  entry_number,
  input  wire logic [14:0] entry_position,
  input  wire logic [7:0]  entry_status,
  input  wire logic [15:0] entry_weak,
  input  wire logic [23:0] entry_start,
  input  wire logic [5:0]  header_count,
  input  wire logic [23:0] header_base,
  input  wire logic [15:0] lookup_sector,
  input  wire logic [14:0] angle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [24:0]      data_offset,
  output logic [7:0]       sector_status,
  output logic [15:0]      weak_offset,
  output logic [14:0]      target_angle,
  output logic [14:0]      distance
);

  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW = TW + SW;
  localparam int NW = $clog2(SLOTS + 1);

  nss_pkg::state_t state, state_next;

  logic [4:0] spt;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) spt <= 5'd18;
    else if (cfg_valid) spt <= cfg_data;
  end

  // memories
  logic [23:0] base_mem [TRACKS];
  logic [5:0]  cnt_mem  [TRACKS];
  logic [TRACKS-1:0] cnt_vld;
  logic [22:0] key_mem  [TRACKS*SLOTS];
  logic [47:0] pay_mem  [TRACKS*SLOTS];

  logic        accept;
  logic        slot_wr, hdr_wr;
  logic [AW-1:0] wr_addr;

  assign in_stall = (state != nss_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign slot_wr  = accept && mode == nss_pkg::MODE_SLOT &&
                    32'(track) < 32'(TRACKS) && 32'(slot) < 32'(SLOTS);
  assign hdr_wr   = accept && mode == nss_pkg::MODE_HEADER && 32'(track) < 32'(TRACKS);
  assign wr_addr  = AW'((32'(track) * 32'(SLOTS)) + 32'(slot));

  // lookup registers
  logic [15:0] sec_q;
  logic [14:0] ang_q;
  logic        div_start, div_done;
  logic [15:0] quo;
  logic [4:0]  rem;
  logic [TW-1:0] trk_q;
  logic [7:0]  want_q;
  logic [5:0]  cnt_rd;
  logic [23:0] base_rd;
  logic [NW-1:0] n_q;
  logic [NW-1:0] idx;
  logic        rd_pend;
  logic [SW-1:0] rd_slot;
  logic [22:0] key_rd;
  logic [47:0] pay_rd;
  logic        have;
  logic [SW-1:0] best;
  logic signed [15:0] min_d, best_d;
  logic signed [15:0] d_cur;
  logic [AW-1:0] rd_addr;
  logic        fetch_wait;
  logic        invalid_req;

  always_ff @(posedge clk) begin
    if (slot_wr) begin
      key_mem[wr_addr] <= {entry_position, entry_number};
      pay_mem[wr_addr] <= {entry_start, entry_weak, entry_status};
    end
    if (hdr_wr) begin
      base_mem[TW'(track)] <= header_base;
      cnt_mem[TW'(track)]  <= header_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cnt_vld <= '0;
    else if (hdr_wr) cnt_vld[TW'(track)] <= 1'b1;
  end

  // the chosen slot stays addressed while the result waits
  assign rd_addr = (state == nss_pkg::ST_FETCH || state == nss_pkg::ST_DONE) ?
                   AW'(32'(trk_q) * 32'(SLOTS) + 32'(best)) :
                   AW'(32'(trk_q) * 32'(SLOTS) + 32'(idx));

  always_ff @(posedge clk) begin
    key_rd  <= key_mem[rd_addr];
    pay_rd  <= pay_mem[rd_addr];
    base_rd <= base_mem[trk_q];
    cnt_rd  <= cnt_vld[trk_q] ? cnt_mem[trk_q] : 6'd0;
  end

  nss_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (lookup_sector - 16'd1),
    .divisor   (spt),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign invalid_req = (sec_q == 16'd0) || (spt == 5'd0);

  // forward distance of the key just read, negative when the angle lies past a revolution
  always_comb begin
    if (key_rd[22:8] >= ang_q) d_cur = 16'(key_rd[22:8]) - 16'(ang_q);
    else d_cur = 16'(key_rd[22:8]) + 16'(nss_pkg::REV_UNITS) - 16'(ang_q);
  end

  logic out_load;
  nss_pkg::result_t res;

  always_comb begin
    state_next = state;
    unique case (state)
      nss_pkg::ST_IDLE:
        if (accept && mode == nss_pkg::MODE_LOOKUP) state_next = nss_pkg::ST_DIV;
      nss_pkg::ST_DIV:
        if (invalid_req) state_next = nss_pkg::ST_DONE;
        else if (div_done) begin
          if (quo >= 16'(nss_pkg::TRACK_LIMIT) || 32'(quo) >= 32'(TRACKS))
            state_next = nss_pkg::ST_DONE;
          else state_next = nss_pkg::ST_TRK;
        end
      // track header read for the final track index
      nss_pkg::ST_TRK:
        state_next = nss_pkg::ST_HDR;
      nss_pkg::ST_HDR:
        state_next = nss_pkg::ST_SCAN;
      nss_pkg::ST_SCAN:
        if (idx == n_q && !rd_pend) state_next = have ? nss_pkg::ST_FETCH : nss_pkg::ST_DONE;
      nss_pkg::ST_FETCH:
        if (fetch_wait) state_next = nss_pkg::ST_DONE;
      nss_pkg::ST_DONE:
        if (!out_valid || !out_stall) state_next = nss_pkg::ST_IDLE;
      default:
        state_next = nss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = (state == nss_pkg::ST_IDLE) && accept && mode == nss_pkg::MODE_LOOKUP;
    out_load  = (state == nss_pkg::ST_DONE) && (!out_valid || !out_stall);
    res = '0;
    if (have) begin
      res.found         = 1'b1;
      res.data_offset   = 25'(base_rd) + 25'(pay_rd[47:24]);
      res.sector_status = pay_rd[7:0];
      res.weak_offset   = pay_rd[23:8];
      res.target_angle  = key_rd[22:8];
      res.distance      = best_d[15] ? 15'd0 : best_d[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= nss_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have    <= 1'b0;
      rd_pend <= 1'b0;
      fetch_wait <= 1'b0;
    end else begin
      unique case (state)
        nss_pkg::ST_IDLE: begin
          have <= 1'b0;
          rd_pend <= 1'b0;
          fetch_wait <= 1'b0;
          if (accept) begin
            sec_q <= lookup_sector;
            ang_q <= angle;
          end
        end
        nss_pkg::ST_DIV: begin
          trk_q  <= TW'(quo);
          want_q <= 8'(rem) + 8'd1;
        end
        nss_pkg::ST_HDR: begin
          idx   <= '0;
          min_d <= 16'(nss_pkg::DIST_START);
          n_q   <= (32'(cnt_rd) > 32'(SLOTS)) ? NW'(SLOTS) : NW'(cnt_rd);
        end
        nss_pkg::ST_SCAN: begin
          rd_pend <= (idx != n_q);
          rd_slot <= SW'(idx);
          if (idx != n_q) idx <= idx + NW'(1);
          if (rd_pend && key_rd[7:0] == want_q) begin
            if (!have) begin
              have   <= 1'b1;
              best   <= rd_slot;
              best_d <= d_cur;
            end
            if (d_cur < min_d) begin
              min_d  <= d_cur;
              best   <= rd_slot;
              best_d <= d_cur;
            end
          end
        end
        nss_pkg::ST_FETCH:
          fetch_wait <= 1'b1;
        nss_pkg::ST_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found         <= res.found;
      data_offset   <= res.data_offset;
      sector_status <= res.sector_status;
      weak_offset   <= res.weak_offset;
      target_angle  <= res.target_angle;
      distance      <= res.distance;
    end
  end

endmodule
`default_nettype wire

[rtl/core/nss_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nss_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        found,
  input wire logic [24:0] data_offset,
  input wire logic [14:0] distance,
  input wire logic [14:0] target_angle
);

  // a not-found result carries zero fields
  `CHK_IMPL(a_zero_miss, clk, rst, out_valid && !found, data_offset == 25'd0 && distance == 15'd0 && target_angle == 15'd0)
  // stalled result holds
  `CHK_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(data_offset))
  // no new result appears in the cycle after an input transfer
  `CHK_NEXT(a_busy, clk, rst, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind nearest_sector_seek_unit nss_checker u_nss_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .found        (found),
  .data_offset  (data_offset),
  .distance     (distance),
  .target_angle (target_angle)
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  localparam int NTRACKS = 128;
  localparam int NSLOTS = 32;
  localparam int RUN_LIMIT = 1500000;

  typedef struct {
    logic [1:0]  mode;
    logic [6:0]  track;
    logic [4:0]  slot;
    logic [7:0]  number;
    logic [14:0] position;
    logic [7:0]  status;
    logic [15:0] weak_ofs;
    logic [23:0] start;
    logic [5:0]  count;
    logic [23:0] base;
    logic [15:0] sector;
    logic [14:0] angle;
  } seek_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [4:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_ready, in_stall, out_valid;
  logic found;
  logic [24:0] data_offset;
  logic [7:0] sector_status;
  logic [15:0] weak_offset;
  logic [14:0] target_angle, distance;

  seek_item_t cur_item = '{default: '0};
  seek_item_t pending_q[$];
  nss_pkg::result_t seek_expected_q[$];
  logic took = 1'b0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;

  // predictor state
  logic [4:0]  spt_model = 5'd18;
  logic [5:0]  count_model[NTRACKS];
  logic [23:0] base_model[NTRACKS];
  logic [7:0]  num_model[NTRACKS*NSLOTS];
  logic [14:0] pos_model[NTRACKS*NSLOTS];
  logic [7:0]  status_model[NTRACKS*NSLOTS];
  logic [15:0] weak_model[NTRACKS*NSLOTS];
  logic [23:0] start_model[NTRACKS*NSLOTS];
  // stimulus side: which slots hold known contents
  bit written[NTRACKS*NSLOTS];
  int spt_gen = 18;

  nearest_sector_seek_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(cur_item.mode), .track(cur_item.track), .slot(cur_item.slot),
    .entry_number(cur_item.number), .entry_position(cur_item.position),
    .entry_status(cur_item.status), .entry_weak(cur_item.weak_ofs),
    .entry_start(cur_item.start), .header_count(cur_item.count),
    .header_base(cur_item.base), .lookup_sector(cur_item.sector),
    .angle(cur_item.angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .data_offset(data_offset), .sector_status(sector_status),
    .weak_offset(weak_offset), .target_angle(target_angle), .distance(distance)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (count_model[i]) count_model[i] = '0;
  end

  task automatic report(input string what, input longint got, input longint want);
    err_cnt++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic seek_predict(input seek_item_t it);
    nss_pkg::result_t r;
    int sec, t, want, n, idx, d, min_d, best, best_d;
    bit have;
    r = '0;
    have = 0;
    best = 0;
    best_d = 0;
    min_d = nss_pkg::DIST_START;
    case (nss_pkg::mode_t'(it.mode))
      nss_pkg::MODE_SLOT: begin
        idx = it.track * NSLOTS + it.slot;
        num_model[idx] = it.number;
        pos_model[idx] = it.position;
        status_model[idx] = it.status;
        weak_model[idx] = it.weak_ofs;
        start_model[idx] = it.start;
      end
      nss_pkg::MODE_HEADER: begin
        count_model[it.track] = it.count;
        base_model[it.track] = it.base;
      end
      nss_pkg::MODE_LOOKUP: begin
        sec = it.sector;
        if (sec != 0 && spt_model != 0) begin
          t = (sec - 1) / spt_model;
          want = (sec - 1) % spt_model + 1;
          if (t < nss_pkg::TRACK_LIMIT && t < NTRACKS) begin
            n = (count_model[t] > NSLOTS) ? NSLOTS : count_model[t];
            for (int i = 0; i < n; i++) begin
              idx = t * NSLOTS + i;
              if (num_model[idx] == want) begin
                d = (pos_model[idx] >= it.angle) ? pos_model[idx] - it.angle
                                                 : pos_model[idx] + nss_pkg::REV_UNITS - it.angle;
                if (!have) begin
                  have = 1;
                  best = i;
                  best_d = d;
                end
                if (d < min_d) begin
                  min_d = d;
                  best = i;
                  best_d = d;
                end
              end
            end
            if (have) begin
              idx = t * NSLOTS + best;
              r.found = 1'b1;
              r.data_offset = 25'(base_model[t]) + 25'(start_model[idx]);
              r.sector_status = status_model[idx];
              r.weak_offset = weak_model[idx];
              r.target_angle = pos_model[idx];
              r.distance = (best_d < 0) ? '0 : 15'(best_d);
            end
          end
        end
        seek_expected_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    took <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) seek_predict(cur_item);
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item = pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    nss_pkg::result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (seek_expected_q.size() == 0) begin
        report("unexpected result, found", found, 0);
      end else begin
        w = seek_expected_q.pop_front();
        if (found !== w.found) report("found", found, w.found);
        if (data_offset !== w.data_offset) report("data_offset", data_offset, w.data_offset);
        if (sector_status !== w.sector_status)
          report("sector_status", sector_status, w.sector_status);
        if (weak_offset !== w.weak_offset) report("weak_offset", weak_offset, w.weak_offset);
        if (target_angle !== w.target_angle)
          report("target_angle", target_angle, w.target_angle);
        if (distance !== w.distance) report("distance", distance, w.distance);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // header writes only go through push_header, which fills the slots first
  function automatic seek_item_t noise_item();
    seek_item_t it;
    it.mode = 2'($urandom);
    if (it.mode == nss_pkg::MODE_HEADER) it.mode = nss_pkg::MODE_NONE;
    it.track = 7'($urandom);
    it.slot = 5'($urandom);
    it.number = 8'($urandom);
    it.position = 15'($urandom);
    it.status = 8'($urandom);
    it.weak_ofs = 16'($urandom);
    it.start = 24'($urandom);
    it.count = 6'($urandom);
    it.base = 24'($urandom);
    it.sector = 16'($urandom);
    it.angle = 15'($urandom);
    return it;
  endfunction

  task automatic push_slot(input int t, input int s, input int num, input int pos);
    seek_item_t it;
    it = noise_item();
    it.mode = nss_pkg::MODE_SLOT;
    it.track = 7'(t);
    it.slot = 5'(s);
    it.number = 8'((num < 0) ? (($urandom_range(99) < 75) ? $urandom_range(1, 26)
                                                          : $urandom_range(0, 255)) : num);
    it.position = 15'((pos < 0) ? (($urandom_range(99) < 85) ? $urandom_range(0, 26041)
                                                             : $urandom_range(26042, 32767))
                                : pos);
    written[t * NSLOTS + s] = 1;
    pending_q.push_back(it);
  endtask

  // slots below the count are written first so no lookup reads an unknown entry
  task automatic push_header(input int t, input int cnt);
    seek_item_t it;
    int lim;
    lim = (cnt > NSLOTS) ? NSLOTS : cnt;
    for (int s = 0; s < lim; s++)
      if (!written[t * NSLOTS + s]) push_slot(t, s, -1, -1);
    it = noise_item();
    it.mode = nss_pkg::MODE_HEADER;
    it.track = 7'(t);
    it.count = 6'(cnt);
    pending_q.push_back(it);
  endtask

  task automatic push_lookup(input int sec, input int ang);
    seek_item_t it;
    it = noise_item();
    it.mode = nss_pkg::MODE_LOOKUP;
    it.sector = 16'(sec);
    it.angle = 15'((ang < 0) ? $urandom_range(0, 32767) : ang);
    pending_q.push_back(it);
  endtask

  function automatic int focus_track();
    return ($urandom_range(99) < 80) ? $urandom_range(0, 11) : $urandom_range(0, 127);
  endfunction

  task automatic gen_random(input int n);
    int k, t;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      t = focus_track();
      if (k < 12) begin
        push_slot(t, ($urandom_range(99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 31),
                  -1, -1);
      end else if (k < 20) begin
        push_header(t, ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(0, 63));
      end else if (k < 90) begin
        if (spt_gen == 0) push_lookup($urandom_range(0, 65535), -1);
        else push_lookup(t * spt_gen + $urandom_range(1, spt_gen), -1);
      end else begin
        pending_q.push_back(noise_item());
      end
    end
  endtask

  task automatic wait_drained();
    wait (pending_q.size() == 0 && !in_valid && seek_expected_q.size() == 0);
    // writes give no result, so let the last one finish
    repeat (80) @(posedge clk);
  endtask

  task automatic set_spt(input int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= 5'(v);
    do @(posedge clk); while (!cfg_ready);
    spt_model = 5'(v);
    spt_gen = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int spt_list[8] = '{18, 26, 0, 31, 1, 22, 18, 26};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_spt(18);

    // directed: extremes, ties, beyond-revolution positions, out-of-range tracks
    push_slot(0, 0, 5, 100);
    push_slot(0, 1, 5, 100);
    push_slot(0, 2, 5, 26041);
    push_slot(0, 3, 18, 32767);
    push_header(0, 4);
    push_lookup(5, 100);
    push_lookup(5, 101);
    push_lookup(5, 32767);
    push_lookup(18, 0);
    push_lookup(0, 0);
    push_lookup(1801, 0);
    push_lookup(65535, 32767);
    push_slot(99, 31, 1, 0);
    push_header(99, 63);
    push_lookup(99 * 18 + 1, 26041);
    push_header(127, 32);
    push_lookup(7, 0);
    pending_q.push_back(noise_item());
    gen_random(20);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      set_spt(spt_list[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 64; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 64; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      if (ph == 0) hold_cycles = 600;
      gen_random(120);
      if (ph == 4) begin
        // sender pauses until everything has come back
        wait (pending_q.size() == 0 && !in_valid && seek_expected_q.size() == 0);
      end
      gen_random(120);
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/nss_pkg.sv
rtl/core/nss_divider.sv
rtl/core/nearest_sector_seek_unit.sv
rtl/core/nss_checker.sv
tb/tb_top.sv
